// ===== rtl/rtu_frame_gap_receiver_macros.svh =====
// Assertion helpers for the RTU frame receiver
`ifndef RTU_FRAME_GAP_RECEIVER_MACROS_SVH
`define RTU_FRAME_GAP_RECEIVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RTU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RTU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rtu_fgr_pkg.sv =====
`default_nettype none

package rtu_fgr_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int LEN_W        = $clog2(BUFFER_BYTES + 1);
    localparam int ADDR_W       = $clog2(2 * BUFFER_BYTES);
    localparam int CMP_W        = (LEN_W > 8) ? LEN_W : 8;
    localparam int TICK_W       = 12;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2,
        OP_RESET = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_SHORT_GAP  = 2'd0,
        CFG_BYTE_GAP   = 2'd1,
        CFG_SILENCE    = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    // result fields apart from the read byte
    typedef struct packed {
        logic       frame_ready;
        logic [8:0] frame_length;
        logic       frame_bad_gap;
        logic       frame_overflowed;
        logic       frame_closed;
        logic       frame_dropped;
        logic       gap_flagged;
        logic       overflow_flagged;
        logic       byte_unexpected;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/rtu_fgr_ram.sv =====
`default_nettype none

module rtu_fgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rtu_frame_gap_receiver.sv =====
// A result passes through stage 1 and the output register before it is shown.
// Throughput: one request per cycle while o_in_stall is low. The single-port
// frame store takes a byte write or a pending-frame read per request, not both.
// Reset (i_rst_n low, synchronous): registers back to 15/35/35, receiver idle,
// nothing pending; frame store contents are left as they are.
`default_nettype none

module rtu_frame_gap_receiver
    import rtu_fgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic        i_listening,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [7:0]  i_read_index,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_frame_ready,
    output logic [8:0]       o_frame_length,
    output logic             o_frame_bad_gap,
    output logic             o_frame_overflowed,
    output logic [7:0]       o_read_data,
    output logic             o_frame_closed,
    output logic             o_frame_dropped,
    output logic             o_gap_flagged,
    output logic             o_overflow_flagged,
    output logic             o_byte_unexpected,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data
);

    // configuration
    logic [TICK_W-1:0] r_short_gap, r_byte_gap, r_silence;

    // receiver state
    logic [TICK_W-1:0] r_gap, n_gap;
    logic [LEN_W-1:0]  r_act_len, n_act_len, r_pend_len, n_pend_len;
    logic r_act_sel, n_act_sel, r_pend_sel, n_pend_sel;
    logic r_in_frame, n_in_frame, r_act_bad, n_act_bad, r_act_over, n_act_over;
    logic r_pend, n_pend, r_pend_bad, n_pend_bad, r_pend_over, n_pend_over;

    // pipeline
    logic    r_s1_valid, r_s1_rd;
    t_status r_s1, n_s1;
    logic    r_out_valid;
    t_status r_out;
    logic [7:0] r_out_data;

    logic in_acc, out_free, s1_free;
    t_op  op;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr, wr_addr, rd_addr;
    logic [7:0]        ram_q;

    logic do_close, gap_flag, over_flag, unexpected;
    logic [TICK_W-1:0] gap_inc;
    logic [LEN_W-1:0]  len_e;
    logic sel_e, bad_e, over_e;
    logic rd_hit;

    assign op          = t_op'(i_operation);
    assign o_cfg_ready = 1'b1;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_stall = !s1_free;
    assign in_acc     = i_in_valid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_gap <= TICK_W'(15);
            r_byte_gap  <= TICK_W'(35);
            r_silence   <= TICK_W'(35);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SHORT_GAP: r_short_gap <= i_cfg_data;
                CFG_BYTE_GAP:  r_byte_gap  <= i_cfg_data;
                CFG_SILENCE:   r_silence   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign rd_hit = r_pend && (CMP_W'(i_read_index) < CMP_W'(r_pend_len))
                    && (CMP_W'(i_read_index) < CMP_W'(BUFFER_BYTES));
    assign rd_addr = r_pend_sel ? ADDR_W'(BUFFER_BYTES) + ADDR_W'(i_read_index)
                                : ADDR_W'(i_read_index);

    always_comb begin
        n_gap       = r_gap;
        n_act_len   = r_act_len;
        n_pend_len  = r_pend_len;
        n_act_sel   = r_act_sel;
        n_pend_sel  = r_pend_sel;
        n_in_frame  = r_in_frame;
        n_act_bad   = r_act_bad;
        n_act_over  = r_act_over;
        n_pend      = r_pend;
        n_pend_bad  = r_pend_bad;
        n_pend_over = r_pend_over;
        do_close    = 1'b0;
        gap_flag    = 1'b0;
        over_flag   = 1'b0;
        unexpected  = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        gap_inc     = (r_gap < r_silence) ? r_gap + TICK_W'(1) : r_gap;
        len_e       = r_act_len;
        sel_e       = r_act_sel;
        bad_e       = r_act_bad;
        over_e      = r_act_over;
        wr_addr     = '0;

        case (op)
            OP_BYTE: begin
                if (!i_listening) begin
                    unexpected = 1'b1;
                end else begin
                    if (r_in_frame) begin
                        if (r_gap >= r_byte_gap) begin
                            do_close = 1'b1;
                        end else if (r_gap > r_short_gap && !r_act_bad) begin
                            gap_flag = 1'b1;
                        end
                    end
                    // state of the active frame once any close has been applied
                    if (do_close) begin
                        len_e  = '0;
                        bad_e  = 1'b0;
                        over_e = 1'b0;
                        sel_e  = r_pend ? r_act_sel : !r_act_sel;
                    end else begin
                        bad_e = r_act_bad || gap_flag;
                    end
                    n_gap      = '0;
                    n_in_frame = 1'b1;
                    n_act_sel  = sel_e;
                    n_act_bad  = bad_e;
                    n_act_over = over_e;
                    n_act_len  = len_e;
                    wr_addr    = sel_e ? ADDR_W'(BUFFER_BYTES) + ADDR_W'(len_e)
                                       : ADDR_W'(len_e);
                    if (!bad_e && !over_e) begin
                        if (len_e >= LEN_W'(BUFFER_BYTES)) begin
                            n_act_over = 1'b1;
                            over_flag  = 1'b1;
                        end else begin
                            ram_we    = in_acc;
                            n_act_len = len_e + LEN_W'(1);
                        end
                    end
                end
            end
            OP_TICK: begin
                if (i_listening && r_in_frame) begin
                    n_gap = gap_inc;
                    if (gap_inc >= r_silence) begin
                        do_close   = 1'b1;
                        n_gap      = '0;
                        n_act_len  = '0;
                        n_in_frame = 1'b0;
                        n_act_bad  = 1'b0;
                        n_act_over = 1'b0;
                        n_act_sel  = r_pend ? r_act_sel : !r_act_sel;
                    end
                end
            end
            OP_READ: begin
                ram_re = in_acc && rd_hit;
            end
            default: begin
                n_gap       = '0;
                n_act_len   = '0;
                n_pend_len  = '0;
                n_act_sel   = 1'b0;
                n_pend_sel  = 1'b0;
                n_in_frame  = 1'b0;
                n_act_bad   = 1'b0;
                n_act_over  = 1'b0;
                n_pend      = 1'b0;
                n_pend_bad  = 1'b0;
                n_pend_over = 1'b0;
            end
        endcase

        // publish the closed frame unless one is already waiting
        if (do_close && !r_pend) begin
            n_pend      = 1'b1;
            n_pend_sel  = r_act_sel;
            n_pend_len  = r_act_len;
            n_pend_bad  = r_act_bad;
            n_pend_over = r_act_over;
        end

        n_s1.frame_ready      = n_pend;
        n_s1.frame_length     = n_pend ? 9'(n_pend_len) : 9'd0;
        n_s1.frame_bad_gap    = n_pend && n_pend_bad;
        n_s1.frame_overflowed = n_pend && n_pend_over;
        n_s1.frame_closed     = do_close && !r_pend;
        n_s1.frame_dropped    = do_close && r_pend;
        n_s1.gap_flagged      = gap_flag;
        n_s1.overflow_flagged = over_flag;
        n_s1.byte_unexpected  = unexpected;
    end

    assign ram_addr = ram_we ? wr_addr : rd_addr;

    rtu_fgr_ram #(
        .WIDTH (8),
        .DEPTH (2 * BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_rx_byte),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap       <= '0;
            r_act_len   <= '0;
            r_pend_len  <= '0;
            r_act_sel   <= 1'b0;
            r_pend_sel  <= 1'b0;
            r_in_frame  <= 1'b0;
            r_act_bad   <= 1'b0;
            r_act_over  <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_bad  <= 1'b0;
            r_pend_over <= 1'b0;
        end else if (in_acc) begin
            r_gap       <= n_gap;
            r_act_len   <= n_act_len;
            r_pend_len  <= n_pend_len;
            r_act_sel   <= n_act_sel;
            r_pend_sel  <= n_pend_sel;
            r_in_frame  <= n_in_frame;
            r_act_bad   <= n_act_bad;
            r_act_over  <= n_act_over;
            r_pend      <= n_pend;
            r_pend_bad  <= n_pend_bad;
            r_pend_over <= n_pend_over;
        end
    end

    // store output holds while stage 1 waits: no new read is issued then
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= in_acc;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1    <= n_s1;
            r_s1_rd <= (op == OP_READ) && rd_hit;
        end
        if (out_free && r_s1_valid) begin
            r_out      <= r_s1;
            r_out_data <= r_s1_rd ? ram_q : 8'd0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_frame_ready      = r_out.frame_ready;
    assign o_frame_length     = r_out.frame_length;
    assign o_frame_bad_gap    = r_out.frame_bad_gap;
    assign o_frame_overflowed = r_out.frame_overflowed;
    assign o_read_data        = r_out_data;
    assign o_frame_closed     = r_out.frame_closed;
    assign o_frame_dropped    = r_out.frame_dropped;
    assign o_gap_flagged      = r_out.gap_flagged;
    assign o_overflow_flagged = r_out.overflow_flagged;
    assign o_byte_unexpected  = r_out.byte_unexpected;

endmodule

`default_nettype wire

// ===== rtl/rtu_fgr_checker.sv =====
`default_nettype none
`include "rtu_frame_gap_receiver_macros.svh"

module rtu_fgr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_frame_ready,
    input wire logic [8:0]  o_frame_length,
    input wire logic        o_frame_bad_gap,
    input wire logic        o_frame_overflowed,
    input wire logic [7:0]  o_read_data,
    input wire logic        o_frame_closed,
    input wire logic        o_frame_dropped,
    input wire logic        o_gap_flagged,
    input wire logic        o_overflow_flagged,
    input wire logic        o_byte_unexpected
);

    // a held result keeps its frame status
    `RTU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_frame_length) && $stable(o_read_data),
        "result changed while stalled")

    `RTU_ASSERT_NOW(a_close_excl, o_out_valid,
        !(o_frame_closed && o_frame_dropped), "frame both closed and dropped")

    // any close leaves a frame pending, published now or earlier
    `RTU_ASSERT_NOW(a_close_pend, o_out_valid && (o_frame_closed || o_frame_dropped),
        o_frame_ready, "close without a pending frame")

    `RTU_ASSERT_NOW(a_idle_status, o_out_valid && !o_frame_ready,
        o_frame_length == 9'd0 && !o_frame_bad_gap && !o_frame_overflowed,
        "frame status shown with nothing pending")

    `RTU_ASSERT_NOW(a_byte_only, o_out_valid && o_byte_unexpected,
        !o_gap_flagged && !o_overflow_flagged && !o_frame_closed && !o_frame_dropped,
        "ignored byte changed the frame")

endmodule

bind rtu_frame_gap_receiver rtu_fgr_checker u_rtu_fgr_checker (.*);

`default_nettype wire
